// ===== hw/rtl/lcs_pkg.sv =====
// Shared types and constants for the lottery scheduler core.
// Depends on nothing; the scheduler core and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none
package lcs_pkg;
   localparam logic CMD_ADMIT = 1'b0;
   localparam logic CMD_TICK  = 1'b1;
   localparam int   CSR_RESET_TICKETS = 100;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  pid;
      logic [7:0]  share;
      logic [15:0] burst;
      logic [30:0] random_value;
   } req_type;

   typedef struct packed {
      logic        ran;
      logic [7:0]  ran_pid;
      logic        first_run;
      logic        finished;
      logic [31:0] tick_time;
      logic        admit_refused;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/lcs_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // One write or one read per cycle; read data is registered and appears in the next cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lcs_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used for the modulo reduction and the ticket shares.
`timescale 1ns / 1ps
`default_nettype none
module lcs_divider #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic      [WIDTH-1:0] quotient,
   output logic      [WIDTH-1:0] remainder
);
   localparam int CW = $clog2(WIDTH + 1);
   logic [WIDTH-1:0] rem_ff, quo_ff, div_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [WIDTH:0]   trial;

   assign trial     = {rem_ff, quo_ff[WIDTH-1]} - {1'b0, div_ff};
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // Shift in one dividend bit a cycle and subtract when it fits.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            div_ff  <= divisor;
            cnt_ff  <= CW'(WIDTH);
         end else if (busy_ff) begin
            if (!trial[WIDTH]) begin
               rem_ff <= trial[WIDTH-1:0];
               quo_ff <= {quo_ff[WIDTH-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
               quo_ff <= {quo_ff[WIDTH-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lottery_cpu_scheduler_core.sv =====
// Lottery scheduler core: slot table and ticket table in synchronous RAMs.
// Depends on lcs_pkg, lcs_ram and lcs_divider.
// Flow: a tick runs the modulo divide of the random value and the slot search; an
// admit or a finishing tick adds a rebuild (T effective tickets): on a removal the
// later slots shift down first, then come T entry clears, a sum of the shares, and
// per slot a share divide and up to T fills.
// After reset a clearing pass over all MAX_TICKETS ticket entries runs; busy is high during it.
// One item at a time; the result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module lottery_cpu_scheduler_core
   import lcs_pkg::*;
#(
   parameter int MAX_PROCS   = 16,
   parameter int MAX_TICKETS = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    csr_write,
   input  wire logic [10:0] csr_wdata
);
   localparam int PW = $clog2(MAX_PROCS);
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int TW = $clog2(MAX_TICKETS);
   localparam int TC = $clog2(MAX_TICKETS + 1);
   localparam int UW = $clog2(MAX_PROCS * 255 + 1);
   localparam int SW = 33;   // pid, share, remaining, started
   localparam int OW = 9;    // owned flag and pid

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ADMIT_WR, S_MOD_START, S_MOD_WAIT, S_OWN_RD, S_OWN_WAIT,
      S_FIND_RD, S_FIND_CHK, S_UPDATE, S_SHIFT_RD, S_SHIFT_WR,
      S_RB_CLEAR, S_RB_SUM_RD, S_RB_SUM, S_RB_SLOT_RD, S_RB_DIV, S_RB_DIV_WAIT,
      S_RB_FILL, S_DONE
   } state_type;

   state_type    state_ff;
   logic [10:0]  tickets_ff;
   logic [CW-1:0] count_ff;
   logic [TC-1:0] assigned_ff, eff_ff, cnt_ff, fill_ff;
   logic [CW-1:0] k_ff;
   logic [31:0]  tick_ff;
   logic [UW-1:0] total_ff;
   req_type      req_ff;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff;
   logic [7:0]   tgt_pid_ff;
   logic [SW-1:0] hold_ff;

   // Slot RAM control.
   logic          s_we;
   logic [PW-1:0] s_addr;
   logic [SW-1:0] s_wdata, s_rdata;
   // Ticket RAM control.
   logic          t_we;
   logic [TW-1:0] t_addr;
   logic [OW-1:0] t_wdata, t_rdata;
   // Divider.
   logic          d_start, d_done;
   logic [31:0]   d_a, d_b, d_q, d_r;

   logic [TC-1:0] eff_now;
   logic [15:0]   rem_new;

   lcs_ram #(.WIDTH(SW), .DEPTH(MAX_PROCS)) u_slots (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
   lcs_ram #(.WIDTH(OW), .DEPTH(MAX_TICKETS)) u_tickets (
      .clock(clock), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata));
   lcs_divider #(.WIDTH(32)) u_div (
      .clock(clock), .reset(reset), .start(d_start), .dividend(d_a), .divisor(d_b),
      .done(d_done), .quotient(d_q), .remainder(d_r));

   // Effective ticket count, clamped to one through MAX_TICKETS.
   always_comb begin
      if (tickets_ff == 11'd0) begin
         eff_now = TC'(1);
      end else if (32'(tickets_ff) > 32'(MAX_TICKETS)) begin
         eff_now = TC'(MAX_TICKETS);
      end else begin
         eff_now = TC'(tickets_ff);
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rem_new   = (hold_ff[16:1] <= 16'd1) ? 16'd0 : hold_ff[16:1] - 16'd1;

   // Memory address, write and divider operand selection per state.
   always_comb begin
      s_we = 1'b0; s_addr = k_ff[PW-1:0]; s_wdata = '0;
      t_we = 1'b0; t_addr = cnt_ff[TW-1:0]; t_wdata = '0;
      d_start = 1'b0; d_a = '0; d_b = '0;
      case (state_ff)
         S_CLEAR, S_RB_CLEAR: begin
            t_we = 1'b1;
         end
         S_ADMIT_WR: begin
            s_we = 1'b1; s_addr = count_ff[PW-1:0];
            s_wdata = {req_ff.pid, req_ff.share, req_ff.burst, 1'b0};
         end
         S_MOD_START: begin
            d_start = 1'b1; d_a = {1'b0, req_ff.random_value}; d_b = 32'(eff_ff);
         end
         S_OWN_RD: begin
            t_addr = d_r[TW-1:0];
         end
         S_UPDATE: begin
            s_we = 1'b1;
            s_wdata = {hold_ff[32:17], rem_new, 1'b1};
         end
         S_SHIFT_WR: begin
            s_we = 1'b1; s_addr = PW'(k_ff - CW'(1)); s_wdata = s_rdata;
         end
         S_RB_DIV: begin
            d_start = 1'b1; d_a = 32'(s_rdata[24:17]) * 32'(eff_ff); d_b = 32'(total_ff);
         end
         S_RB_FILL: begin
            // Only write while this slot still has tickets and the table has room.
            t_we = (fill_ff != '0) && (assigned_ff < eff_ff);
            t_addr = assigned_ff[TW-1:0];
            t_wdata = {1'b1, hold_ff[32:25]};
         end
         default: ;
      endcase
   end

   // Control sequencer: reset clear, admit, tick, slot removal and ticket rebuild.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         tickets_ff   <= 11'(CSR_RESET_TICKETS);
         count_ff     <= '0;
         assigned_ff  <= '0;
         tick_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            tickets_ff <= csr_wdata;
         end
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + TC'(1);
               if (cnt_ff == TC'(MAX_TICKETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  eff_ff <= eff_now;
                  rsp_ff <= '{ran: 1'b0, ran_pid: 8'd0, first_run: 1'b0, finished: 1'b0,
                              tick_time: tick_ff,
                              admit_refused: (req_data.cmd == CMD_ADMIT) &&
                                             (32'(count_ff) >= 32'(MAX_PROCS))};
                  if (req_data.cmd == CMD_ADMIT) begin
                     if (32'(count_ff) >= 32'(MAX_PROCS)) begin
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_ADMIT_WR;
                     end
                  end else begin
                     tick_ff <= tick_ff + 32'd1;
                     state_ff <= (count_ff == '0) ? S_DONE : S_MOD_START;
                  end
               end
            end
            S_ADMIT_WR: begin
               count_ff <= count_ff + CW'(1);
               cnt_ff   <= '0;
               state_ff <= S_RB_CLEAR;
            end
            S_MOD_START: state_ff <= S_MOD_WAIT;
            S_MOD_WAIT: if (d_done) state_ff <= S_OWN_RD;
            S_OWN_RD: state_ff <= S_OWN_WAIT;
            S_OWN_WAIT: begin
               if (!t_rdata[8]) begin
                  state_ff <= S_DONE;
               end else begin
                  tgt_pid_ff <= t_rdata[7:0];
                  k_ff <= '0;
                  state_ff <= S_FIND_RD;
               end
            end
            S_FIND_RD: state_ff <= S_FIND_CHK;
            S_FIND_CHK: begin
               if (s_rdata[32:25] == tgt_pid_ff) begin
                  hold_ff <= s_rdata;
                  state_ff <= S_UPDATE;
               end else if (k_ff + CW'(1) >= count_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  k_ff <= k_ff + CW'(1);
                  state_ff <= S_FIND_RD;
               end
            end
            S_UPDATE: begin
               rsp_ff <= '{ran: 1'b1, ran_pid: tgt_pid_ff, first_run: ~hold_ff[0],
                           finished: (hold_ff[16:1] <= 16'd1),
                           tick_time: rsp_ff.tick_time, admit_refused: 1'b0};
               if (hold_ff[16:1] <= 16'd1) begin
                  k_ff <= k_ff + CW'(1);
                  state_ff <= S_SHIFT_RD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_SHIFT_RD: begin
               if (k_ff >= count_ff) begin
                  count_ff <= count_ff - CW'(1);
                  cnt_ff   <= '0;
                  state_ff <= S_RB_CLEAR;
               end else begin
                  state_ff <= S_SHIFT_WR;
               end
            end
            S_SHIFT_WR: begin
               k_ff <= k_ff + CW'(1);
               state_ff <= S_SHIFT_RD;
            end
            S_RB_CLEAR: begin
               cnt_ff <= cnt_ff + TC'(1);
               if (cnt_ff + TC'(1) >= eff_ff) begin
                  assigned_ff <= '0;
                  total_ff <= '0;
                  k_ff <= '0;
                  state_ff <= (count_ff == '0) ? S_DONE : S_RB_SUM_RD;
               end
            end
            S_RB_SUM_RD: state_ff <= S_RB_SUM;
            S_RB_SUM: begin
               total_ff <= total_ff + UW'(s_rdata[24:17]);
               if (k_ff + CW'(1) >= count_ff) begin
                  k_ff <= '0;
                  state_ff <= S_RB_SLOT_RD;
               end else begin
                  k_ff <= k_ff + CW'(1);
                  state_ff <= S_RB_SUM_RD;
               end
            end
            S_RB_SLOT_RD: begin
               state_ff <= (total_ff == '0) ? S_DONE : S_RB_DIV;
            end
            S_RB_DIV: begin
               hold_ff <= s_rdata;
               state_ff <= S_RB_DIV_WAIT;
            end
            S_RB_DIV_WAIT: begin
               if (d_done) begin
                  fill_ff <= TC'(d_q);
                  state_ff <= S_RB_FILL;
               end
            end
            S_RB_FILL: begin
               if (fill_ff == '0 || assigned_ff >= eff_ff) begin
                  if (k_ff + CW'(1) >= count_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     k_ff <= k_ff + CW'(1);
                     state_ff <= S_RB_SLOT_RD;
                  end
               end else begin
                  assigned_ff <= assigned_ff + TC'(1);
                  fill_ff <= fill_ff - TC'(1);
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== test/lottery_cpu_scheduler_core_tb.sv =====
// Self-checking testbench for the lottery scheduler core: admits, ticks and ticket-count writes.
// Depends on lcs_pkg and lottery_cpu_scheduler_core; a behavioral scheduler predicts each result.
`timescale 1ns / 1ps
`default_nettype none
module lottery_cpu_scheduler_core_tb
   import lcs_pkg::*;
;
   localparam int NPROC = 16;
   localparam int NTIX  = 1024;
   localparam int MAX_MISMATCH_REPORTS = 10;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type      req_data;
   logic         rsp_valid;
   rsp_type      rsp_data;
   logic         csr_write;
   logic [10:0]  csr_wdata;

   // Scheduler mirror.
   logic [10:0]  tickets_reg;
   logic [7:0]   m_pid   [NPROC];
   logic [7:0]   m_share [NPROC];
   logic [15:0]  m_left  [NPROC];
   logic         m_begun [NPROC];
   int           m_count;
   logic [8:0]   owner_tab [NTIX];
   logic [31:0]  ticks;

   rsp_type      pending_rsp[$];
   int           mismatches;
   int           failures;
   bit           idle_free;

   lottery_cpu_scheduler_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int active_tickets();
      int n;
      n = tickets_reg;
      if (n == 0) n = 1;
      if (n > NTIX) n = NTIX;
      return n;
   endfunction

   // Clear the first T entries and hand out contiguous runs by share.
   function automatic void redraw_tickets();
      int t, total, k, n, pos;
      t = active_tickets();
      total = 0;
      pos = 0;
      for (int i = 0; i < t; i++) owner_tab[i] = '0;
      for (int i = 0; i < m_count; i++) total += m_share[i];
      if (total == 0) return;
      for (int i = 0; i < m_count; i++) begin
         n = (int'(m_share[i]) * t) / total;
         for (k = 0; k < n && pos < t; k++) begin
            owner_tab[pos] = {1'b1, m_pid[i]};
            pos++;
         end
      end
   endfunction

   function automatic rsp_type schedule(req_type rq);
      rsp_type r;
      int idx, k;
      logic [8:0] own;
      r = '0;
      r.tick_time = ticks;
      if (rq.cmd == CMD_ADMIT) begin
         if (m_count >= NPROC) begin
            r.admit_refused = 1'b1;
         end else begin
            m_pid[m_count]   = rq.pid;
            m_share[m_count] = rq.share;
            m_left[m_count]  = rq.burst;
            m_begun[m_count] = 1'b0;
            m_count++;
            redraw_tickets();
         end
      end else begin
         ticks++;
         if (m_count > 0) begin
            idx = int'(rq.random_value % active_tickets());
            own = owner_tab[idx];
            if (own[8]) begin
               k = 0;
               while (k < m_count && m_pid[k] != own[7:0]) k++;
               if (k < m_count) begin
                  r.ran = 1'b1;
                  r.ran_pid = own[7:0];
                  r.first_run = !m_begun[k];
                  m_begun[k] = 1'b1;
                  if (m_left[k] <= 1) begin
                     r.finished = 1'b1;
                     for (int i = k; i + 1 < m_count; i++) begin
                        m_pid[i] = m_pid[i+1];
                        m_share[i] = m_share[i+1];
                        m_left[i] = m_left[i+1];
                        m_begun[i] = m_begun[i+1];
                     end
                     m_count--;
                     redraw_tickets();
                  end else begin
                     m_left[k]--;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   // Result checker: every strobe is a transfer that cannot be held off.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            failures++;
            if (mismatches < MAX_MISMATCH_REPORTS) $display("unexpected result %p", rsp_data);
            mismatches++;
         end else begin
            if (rsp_data !== pending_rsp[0]) begin
               failures++;
               if (mismatches < MAX_MISMATCH_REPORTS)
                  $display("mismatch: expected %p actual %p", pending_rsp[0], rsp_data);
               mismatches++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   task automatic write_tickets(logic [10:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= val;
      tickets_reg = val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Drops start, waits for all results, then idles the clock for quiet before returning.
   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_rsp.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (1700) @(posedge clock);
   endtask

   // One transfer: hold start until the block takes the item. Start stays high
   // after the transfer so that the next item can follow without a gap.
   task automatic send(req_type rq, bit has_exp, rsp_type given);
      rsp_type e;
      if (!idle_free) begin
         while ($urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      e = schedule(rq);
      if (has_exp && e !== given) begin
         failures++;
         $display("table row disagrees with prediction: %p vs %p", given, e);
      end
      pending_rsp = {pending_rsp, e};
   endtask

   function automatic req_type mk(logic c, logic [7:0] p, logic [7:0] s,
                                  logic [15:0] b, logic [30:0] rv);
      req_type rq;
      rq.cmd = c; rq.pid = p; rq.share = s; rq.burst = b; rq.random_value = rv;
      return rq;
   endfunction

   function automatic rsp_type mkr(logic ran, logic [7:0] p, logic f, logic fin,
                                   logic [31:0] tt, logic refused);
      rsp_type r;
      r.ran = ran; r.ran_pid = p; r.first_run = f; r.finished = fin;
      r.tick_time = tt; r.admit_refused = refused;
      return r;
   endfunction

   typedef struct {
      req_type rq;
      bit      known;
      rsp_type want;
   } row_type;

   row_type stim_rows[$];

   function automatic void add_row(req_type rq, bit known, rsp_type want);
      row_type r;
      r.rq = rq;
      r.known = known;
      r.want = want;
      stim_rows = {stim_rows, r};
   endfunction

   function automatic req_type rand_req(int mode);
      req_type rq;
      rq.cmd = ($urandom_range(99) < 30) ? CMD_ADMIT : CMD_TICK;
      rq.pid = (mode == 0) ? 8'($urandom_range(7)) : 8'($urandom);
      rq.share = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom);
      rq.burst = ($urandom_range(9) == 0) ? 16'($urandom) :
                 16'($urandom_range(6));
      rq.random_value = 31'($urandom);
      return rq;
   endfunction

   initial begin
      logic [10:0] tix_plan[6];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_wdata = 11'd0;
      tickets_reg = 11'(CSR_RESET_TICKETS);
      m_count = 0;
      ticks = '0;
      mismatches = 0;
      failures = 0;
      idle_free = 1'b0;
      for (int i = 0; i < NTIX; i++) owner_tab[i] = '0;
      for (int i = 0; i < NPROC; i++) begin
         m_pid[i] = '0; m_share[i] = '0; m_left[i] = '0; m_begun[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table: empty ticks, extremes, zero burst, zero share, duplicates, full slots.
      add_row(mk(CMD_TICK, 0, 0, 0, 31'h7fffffff), 1, mkr(0, 0, 0, 0, 0, 0));
      add_row(mk(CMD_ADMIT, 8'hff, 8'hff, 16'hffff, 0), 1, mkr(0, 0, 0, 0, 1, 0));
      add_row(mk(CMD_TICK, 0, 0, 0, 0), 1, mkr(1, 8'hff, 1, 0, 1, 0));
      add_row(mk(CMD_TICK, 0, 0, 0, 31'd99), 1, mkr(1, 8'hff, 0, 0, 2, 0));
      add_row(mk(CMD_ADMIT, 8'd0, 8'd0, 16'd0, 31'h55555555), 0, '0);
      add_row(mk(CMD_ADMIT, 8'd7, 8'd1, 16'd0, 0), 0, '0);
      add_row(mk(CMD_ADMIT, 8'hff, 8'd200, 16'd1, 0), 0, '0);
      for (int i = 0; i < 14; i++)
         add_row(mk(CMD_ADMIT, 8'(i + 16), 8'(i), 16'(i + 1), 0), 0, '0);
      for (int i = 0; i < 4; i++)
         add_row(mk(CMD_TICK, 0, 0, 0, 31'($urandom)), 0, '0);
      foreach (stim_rows[i]) send(stim_rows[i].rq, stim_rows[i].known, stim_rows[i].want);
      drain();

      // Random phases across ticket counts, zero and the limits among them.
      tix_plan = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd7, 11'd300};
      for (int ph = 0; ph < 6; ph++) begin
         write_tickets(tix_plan[ph]);
         idle_free = (ph == 3);
         for (int n = 0; n < 90; n++) send(rand_req(ph % 2), 0, '0);
         drain();
      end

      // A result that never arrived is a failure too.
      if (pending_rsp.size() != 0) begin
         failures++;
      end

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_ram.sv
hw/rtl/lcs_divider.sv
hw/rtl/lottery_cpu_scheduler_core.sv
test/lottery_cpu_scheduler_core_tb.sv
